// File: rtl/core/bcrg_pkg.sv
// ----------------------------------------------------------------------------
// bcrg_pkg
// Types, widths, register codes and animation tables for the beat clock and
// reset generator.
// ----------------------------------------------------------------------------
package bcrg_pkg;

  localparam int FRAME_COUNT     = 4;
  localparam int MAX_PPQN        = 24;
  localparam int BEAT_FRAC_BITS  = 16;
  localparam int TEMPO_FRAC_BITS = 8;

  localparam int BEAT_W  = 48;
  localparam int PHASE_W = 23;
  localparam int TEMPO_W = 18;
  localparam int LOOP_W  = 7;
  localparam int PPQ_W   = 5;
  localparam int US_W    = 17;
  localparam int LED_W   = 6;

  localparam int LOOP_MAX = 64;

  localparam int EPB_W  = $clog2(2 * MAX_PPQN + 1);
  localparam int EPL_W  = $clog2(2 * MAX_PPQN * LOOP_MAX + 1);
  localparam int EDGE_W = BEAT_W + EPB_W - BEAT_FRAC_BITS;

  // 60e6 microseconds per minute = 2^8 * 234375
  localparam int US_SCALE_SH  = 8;
  localparam int US_SCALE_ODD = 234375;

  localparam int MUL_A_W = BEAT_W;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;
  localparam int PL_W    = PHASE_W + LOOP_W;
  localparam int LHS_W   = PL_W + MUL_B_W;
  localparam int RHS_W   = US_W + TEMPO_W;
  localparam int CMP_W   = LHS_W + US_SCALE_SH + BEAT_FRAC_BITS;

  localparam int TABLE_ROWS  = 4;
  localparam int FRAME_LIM   = (FRAME_COUNT < TABLE_ROWS) ? FRAME_COUNT : TABLE_ROWS;
  localparam int FRAME_IDX_W = $clog2(TABLE_ROWS);
  localparam int FRM_CMP_W   = PHASE_W + LOOP_W + BEAT_FRAC_BITS;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = US_W;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_BEATS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_QTR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_PULSE_US = 2'd2;

  localparam logic [LED_W-1:0] CUE_FRAMES [TABLE_ROWS] = '{6'h01, 6'h23, 6'h37, 6'h3F};
  localparam logic [LED_W-1:0] PLAY_FRAMES [TABLE_ROWS] = '{6'h01, 6'h06, 6'h08, 6'h30};

  typedef enum logic [1:0] {
    PS_STOPPED = 2'd0,
    PS_CUED    = 2'd1,
    PS_PLAYING = 2'd2
  } play_state_e;

  typedef struct packed {
    logic                      func;
    logic signed [BEAT_W-1:0]  previous_beats;
    logic signed [BEAT_W-1:0]  current_beats;
    logic [PHASE_W-1:0]        current_phase;
    logic [TEMPO_W-1:0]        tempo_bpm;
    logic                      no_peers;
  } bcrg_in_t;

  typedef struct packed {
    logic              clock_write;
    logic              clock_level;
    logic              reset_write;
    logic              reset_level;
    logic              led_write;
    logic [LED_W-1:0]  led_bright_mask;
    logic [1:0]        play_state_out;
    logic              timeline_reset;
  } bcrg_out_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } bcrg_div_sts_t;

endpackage

// File: rtl/core/bcrg_mul.sv
// ----------------------------------------------------------------------------
// bcrg_mul
// Shared signed by unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module bcrg_mul (
  input  logic                                  clk_i,
  input  logic signed [bcrg_pkg::MUL_A_W-1:0]   a_i,
  input  logic        [bcrg_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [bcrg_pkg::MUL_P_W-1:0]   p_o
);

  logic signed [bcrg_pkg::MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * $signed({1'b0, b_i});
  end

  assign p_o = p_q;

endmodule

// File: rtl/core/bcrg_div.sv
// ----------------------------------------------------------------------------
// bcrg_div
// Bit-serial restoring remainder unit, one dividend bit per cycle, reports
// whether the edge count divides evenly by the loop length.
// ----------------------------------------------------------------------------
module bcrg_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [bcrg_pkg::EDGE_W-1:0]     dividend_i,
  input  logic [bcrg_pkg::EPL_W-1:0]      divisor_i,
  output bcrg_pkg::bcrg_div_sts_t         sts_o
);

  localparam int CNT_W = $clog2(bcrg_pkg::EDGE_W + 1);

  logic                            busy_q;
  logic                            done_q;
  logic [CNT_W-1:0]                cnt_q;
  logic [bcrg_pkg::EDGE_W-1:0]     dvd_q;
  logic [bcrg_pkg::EPL_W-1:0]      dsr_q;
  logic [bcrg_pkg::EPL_W-1:0]      rem_q;
  logic [bcrg_pkg::EPL_W:0]        trial;
  logic [bcrg_pkg::EPL_W-1:0]      rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[bcrg_pkg::EDGE_W-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = bcrg_pkg::EPL_W'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[bcrg_pkg::EPL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(bcrg_pkg::EDGE_W);
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[bcrg_pkg::EDGE_W-2:0], 1'b0};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign sts_o.busy     = busy_q;
  assign sts_o.done     = done_q;
  assign sts_o.rem_zero = (rem_q == '0);

endmodule

// File: rtl/core/beat_clock_reset_generator.sv
// ----------------------------------------------------------------------------
// beat_clock_reset_generator
// Play state transport for an analogue clock and reset output following a
// shared beat timeline, with a six-LED animation frame.
// ----------------------------------------------------------------------------
// sequence: a play/stop press goes straight to its result; a tick first takes
//   the five products and, when cued and a new edge needs the loop-start
//   check, runs the remainder unit (38 remainder steps)
// throughput: one item at a time; set by the five products on the shared
//   multiplier and the bit-serial remainder unit
// reset: stopped, loop_beats 4, pulses_per_quarter 4, reset_pulse_us 10000
module beat_clock_reset_generator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  bcrg_pkg::bcrg_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output bcrg_pkg::bcrg_out_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bcrg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bcrg_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_PREV,
    ST_MUL_CUR,
    ST_MUL_PL,
    ST_MUL_UT,
    ST_MUL_LHS,
    ST_EVAL,
    ST_DIV,
    ST_FIN
  } seq_state_e;

  seq_state_e                           state_q;
  bcrg_pkg::play_state_e                play_q;
  bcrg_pkg::bcrg_in_t                   in_q;
  bcrg_pkg::bcrg_out_t                  out_q;
  logic                                 out_valid_q;

  logic [bcrg_pkg::LOOP_W-1:0]          loop_q;
  logic [bcrg_pkg::PPQ_W-1:0]           ppq_q;
  logic [bcrg_pkg::US_W-1:0]            us_q;

  logic signed [bcrg_pkg::EDGE_W-1:0]   prev_e_q;
  logic signed [bcrg_pkg::EDGE_W-1:0]   cur_e_q;
  logic [bcrg_pkg::PL_W-1:0]            pl_q;
  logic [bcrg_pkg::RHS_W-1:0]           rhs_q;
  logic                                 new_edge_q;
  logic                                 rst_lvl_q;
  logic                                 start_q;

  logic [bcrg_pkg::LOOP_W-1:0]          loop_sat;
  logic [bcrg_pkg::PPQ_W-1:0]           ppq_sat;
  logic [bcrg_pkg::EPB_W-1:0]           epb;
  logic [bcrg_pkg::EPL_W-1:0]           epl;

  logic signed [bcrg_pkg::MUL_A_W-1:0]  mul_a;
  logic        [bcrg_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [bcrg_pkg::MUL_P_W-1:0]  mul_p;

  logic                                 div_start;
  logic [bcrg_pkg::EDGE_W-1:0]          cur_mag;
  bcrg_pkg::bcrg_div_sts_t              div_sts;

  logic                                 new_edge;
  logic [bcrg_pkg::LHS_W-1:0]           lhs;
  logic [bcrg_pkg::CMP_W-1:0]           lhs_w;
  logic [bcrg_pkg::CMP_W-1:0]           rhs_w;

  logic [bcrg_pkg::FRM_CMP_W-1:0]       ph_scaled;
  logic [bcrg_pkg::FRAME_IDX_W-1:0]     frame;
  bcrg_pkg::bcrg_out_t                  res;
  bcrg_pkg::play_state_e                play_next;
  bcrg_pkg::play_state_e                play_mid;
  logic                                 in_xfer;
  logic                                 out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // clamp the loop and pulse settings
  always_comb begin
    if (loop_q == '0) begin
      loop_sat = bcrg_pkg::LOOP_W'(1);
    end else if (int'(loop_q) > bcrg_pkg::LOOP_MAX) begin
      loop_sat = bcrg_pkg::LOOP_W'(bcrg_pkg::LOOP_MAX);
    end else begin
      loop_sat = loop_q;
    end
    if (ppq_q == '0) begin
      ppq_sat = bcrg_pkg::PPQ_W'(1);
    end else if (int'(ppq_q) > bcrg_pkg::MAX_PPQN) begin
      ppq_sat = bcrg_pkg::PPQ_W'(bcrg_pkg::MAX_PPQN);
    end else begin
      ppq_sat = ppq_q;
    end
    epb = bcrg_pkg::EPB_W'({ppq_sat, 1'b0});
    epl = bcrg_pkg::EPL_W'(bcrg_pkg::EPL_W'(epb) * bcrg_pkg::EPL_W'(loop_sat));
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_PREV: begin
        mul_a = in_q.previous_beats;
        mul_b = bcrg_pkg::MUL_B_W'(epb);
      end
      ST_MUL_CUR: begin
        mul_a = in_q.current_beats;
        mul_b = bcrg_pkg::MUL_B_W'(epb);
      end
      ST_MUL_PL: begin
        mul_a[bcrg_pkg::PHASE_W-1:0] = in_q.current_phase;
        mul_b = bcrg_pkg::MUL_B_W'(loop_sat);
      end
      ST_MUL_UT: begin
        mul_a[bcrg_pkg::US_W-1:0] = us_q;
        mul_b = bcrg_pkg::MUL_B_W'(in_q.tempo_bpm);
      end
      ST_MUL_LHS: begin
        mul_a[bcrg_pkg::PL_W-1:0] = pl_q;
        mul_b = bcrg_pkg::MUL_B_W'(bcrg_pkg::US_SCALE_ODD);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bcrg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign new_edge  = cur_e_q > prev_e_q;
  assign cur_mag   = cur_e_q[bcrg_pkg::EDGE_W-1] ? bcrg_pkg::EDGE_W'(-cur_e_q)
                                                 : bcrg_pkg::EDGE_W'(cur_e_q);
  assign div_start = (state_q == ST_EVAL) && (play_q == bcrg_pkg::PS_CUED) && new_edge;

  bcrg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur_mag),
    .divisor_i  (epl),
    .sts_o      (div_sts)
  );

  // reset pulse compare, both sides carry a common factor of 2^8
  always_comb begin
    lhs   = mul_p[bcrg_pkg::LHS_W-1:0];
    lhs_w = bcrg_pkg::CMP_W'(lhs) << bcrg_pkg::US_SCALE_SH;
    rhs_w = bcrg_pkg::CMP_W'(rhs_q) << (bcrg_pkg::BEAT_FRAC_BITS - bcrg_pkg::TEMPO_FRAC_BITS);
  end

  // animation frame index, saturating at the last frame
  always_comb begin
    ph_scaled = bcrg_pkg::FRM_CMP_W'(in_q.current_phase) *
                bcrg_pkg::FRM_CMP_W'(bcrg_pkg::FRAME_COUNT);
    frame = '0;
    for (int k = 1; k < bcrg_pkg::FRAME_LIM; k++) begin
      if (ph_scaled >= ((bcrg_pkg::FRM_CMP_W'(k) * bcrg_pkg::FRM_CMP_W'(loop_sat))
                        << bcrg_pkg::BEAT_FRAC_BITS)) begin
        frame = bcrg_pkg::FRAME_IDX_W'(k);
      end
    end
  end

  // result of the item in hand
  always_comb begin
    res       = '0;
    play_next = play_q;
    play_mid  = play_q;
    if (in_q.func) begin
      case (play_q)
        bcrg_pkg::PS_STOPPED: begin
          res.timeline_reset = in_q.no_peers;
          play_next          = bcrg_pkg::PS_CUED;
        end
        bcrg_pkg::PS_CUED,
        bcrg_pkg::PS_PLAYING: begin
          play_next = bcrg_pkg::PS_STOPPED;
        end
        default: begin
          play_next = play_q;
        end
      endcase
    end else begin
      if (play_q == bcrg_pkg::PS_CUED) begin
        if (start_q) begin
          play_mid = bcrg_pkg::PS_PLAYING;
        end else begin
          res.led_write       = 1'b1;
          res.led_bright_mask = bcrg_pkg::CUE_FRAMES[frame];
        end
      end
      if (play_mid == bcrg_pkg::PS_PLAYING) begin
        res.reset_write = 1'b1;
        res.reset_level = rst_lvl_q;
        if (new_edge_q) begin
          res.clock_write     = 1'b1;
          res.clock_level     = !cur_e_q[0];
          res.led_write       = 1'b1;
          res.led_bright_mask = bcrg_pkg::PLAY_FRAMES[frame];
        end
      end else if (play_mid != bcrg_pkg::PS_CUED) begin
        res.clock_write = 1'b1;
        res.reset_write = 1'b1;
        res.led_write   = 1'b1;
      end
      play_next = play_mid;
    end
    res.play_state_out = play_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      play_q      <= bcrg_pkg::PS_STOPPED;
      in_q        <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      loop_q      <= bcrg_pkg::LOOP_W'(4);
      ppq_q       <= bcrg_pkg::PPQ_W'(4);
      us_q        <= bcrg_pkg::US_W'(10000);
      prev_e_q    <= '0;
      cur_e_q     <= '0;
      pl_q        <= '0;
      rhs_q       <= '0;
      new_edge_q  <= 1'b0;
      rst_lvl_q   <= 1'b0;
      start_q     <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_ready_i) || (state_q == ST_FIN);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          bcrg_pkg::CFG_LOOP_BEATS:     loop_q <= cfg_data_i[bcrg_pkg::LOOP_W-1:0];
          bcrg_pkg::CFG_PULSES_PER_QTR: ppq_q  <= cfg_data_i[bcrg_pkg::PPQ_W-1:0];
          bcrg_pkg::CFG_RESET_PULSE_US: us_q   <= cfg_data_i[bcrg_pkg::US_W-1:0];
          default: begin
          end
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            in_q    <= in_data_i;
            state_q <= in_data_i.func ? ST_FIN : ST_MUL_PREV;
          end
        end
        ST_MUL_PREV: begin
          state_q <= ST_MUL_CUR;
        end
        ST_MUL_CUR: begin
          prev_e_q <= mul_p[bcrg_pkg::BEAT_FRAC_BITS +: bcrg_pkg::EDGE_W];
          state_q  <= ST_MUL_PL;
        end
        ST_MUL_PL: begin
          cur_e_q <= mul_p[bcrg_pkg::BEAT_FRAC_BITS +: bcrg_pkg::EDGE_W];
          state_q <= ST_MUL_UT;
        end
        ST_MUL_UT: begin
          pl_q    <= mul_p[bcrg_pkg::PL_W-1:0];
          state_q <= ST_MUL_LHS;
        end
        ST_MUL_LHS: begin
          rhs_q   <= mul_p[bcrg_pkg::RHS_W-1:0];
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          new_edge_q <= new_edge;
          rst_lvl_q  <= (lhs_w <= rhs_w);
          start_q    <= 1'b0;
          state_q    <= div_start ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          if (div_sts.done) begin
            start_q <= div_sts.rem_zero;
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_q   <= res;
            play_q  <= play_next;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/bcrg_checker.sv
// ----------------------------------------------------------------------------
// bcrg_checker
// Port-level checks for the beat clock and reset generator, bound to the
// top level.
// ----------------------------------------------------------------------------
module bcrg_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_o,
  input  bcrg_pkg::bcrg_in_t                   in_data_i,
  input  logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  input  bcrg_pkg::bcrg_out_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_o,
  input  logic [bcrg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bcrg_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one item in flight at a time
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // timeline reset only on a press that cues
  a_tl_reset_cued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.timeline_reset |->
      out_data_o.play_state_out == bcrg_pkg::PS_CUED && !out_data_o.clock_write &&
      !out_data_o.reset_write && !out_data_o.led_write)
    else $error("timeline reset outside a cueing press");

  // stopped outputs are driven low
  a_stopped_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.play_state_out == bcrg_pkg::PS_STOPPED &&
      out_data_o.led_write |->
      out_data_o.led_bright_mask == '0 && !out_data_o.clock_level &&
      !out_data_o.reset_level)
    else $error("stopped tick drives a level");

endmodule

bind beat_clock_reset_generator bcrg_checker u_bcrg_checker (.*);
